/* sv/bucketed_log_index_table_unit_assert.svh */
// Assertion macros for the bucketed log index table unit.
// Depends on nothing; files that check their own logic include it by name.
`ifndef BUCKETED_LOG_INDEX_TABLE_UNIT_ASSERT_SVH
`define BUCKETED_LOG_INDEX_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define BLIT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define BLIT_NEVER(label, clk, rst_n, cond) \
	`BLIT_ASSERT(label, clk, rst_n, !(cond))

`else

`define BLIT_ASSERT(label, clk, rst_n, prop)
`define BLIT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* sv/blit_pkg.sv */
// Shared types and constants of the bucketed log index table unit.
// Depends on nothing; used by the remainder unit and the top level.
package blit_pkg;

	localparam int ID_W     = 20;
	localparam int ORDER_W  = 16;
	localparam int COUNT_W  = 10;
	localparam int STATUS_W = 2;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_RECORD_NEW = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RECORD_OLD = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP_NEW = 2'd2;
	localparam logic [REQ_W-1:0] REQ_LOOKUP_OLD = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

	localparam logic [ORDER_W-1:0] ORDER_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0]  chunk_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                need_old_data;
		logic [ORDER_W-1:0]  log_pos;
		logic [COUNT_W-1:0]  logged_chunks;
	} rsp_t;

	// One slot of a bucket as held in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [ORDER_W-1:0] order;
	} slot_t;

endpackage

/* sv/bucketed_log_index_table_unit.sv */
// Bucketed log index table: two chunk-id tables (new log, old log) with a sequencer.
// Depends on blit_pkg, blit_ram, blit_rem and bucketed_log_index_table_unit_assert.svh.
//
// One request at a time. After acceptance the bucket index is formed from the chunk id by
// reciprocal multiplication, the bucket fill count is read, and the occupied slots are
// read and compared in turn until a match or the last one (skipped for a record into a
// full bucket and for any request into an empty one); the update step then forms the
// result, and the next request is taken once the unit is back in idle. The single slot
// memory port and the one id comparator limit the compare to one slot at a time. After
// reset the fill counts of all 2*NUM_BUCKETS rows are cleared, during which no request
// is taken. Results leave through an output register; the update step waits while that
// register still holds a result that has not been taken.
`include "bucketed_log_index_table_unit_assert.svh"

module bucketed_log_index_table_unit #(
	parameter int NUM_BUCKETS        = 64,
	parameter int ENTRIES_PER_BUCKET = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  blit_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output blit_pkg::rsp_t   rsp
);

	localparam int BW        = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW        = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
	localparam int FW        = $clog2(ENTRIES_PER_BUCKET + 1);
	localparam int ROWS      = 2 * NUM_BUCKETS;
	localparam int FAW       = $clog2(ROWS);
	localparam int SLOTS     = ROWS * ENTRIES_PER_BUCKET;
	localparam int SAW       = $clog2(SLOTS);
	localparam int SLOT_BITS = $bits(blit_pkg::slot_t);

	localparam logic [FW-1:0]  FILL_FULL    = FW'(ENTRIES_PER_BUCKET);
	localparam logic [FAW-1:0] ROW_LAST     = FAW'(ROWS - 1);
	localparam logic [FAW-1:0] ROW_OLD_BASE = FAW'(NUM_BUCKETS);
	localparam logic [SAW-1:0] SLOT_STRIDE  = SAW'(ENTRIES_PER_BUCKET);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_REM   = 8'b0000_0100,
		S_FILL  = 8'b0000_1000,
		S_CHECK = 8'b0001_0000,
		S_RD    = 8'b0010_0000,
		S_CMP   = 8'b0100_0000,
		S_UPD   = 8'b1000_0000
	} state_t;

	state_t                              state_q;
	blit_pkg::req_t                      req_q;
	logic                                is_rec_q;
	logic                                use_old_q;
	logic [BW-1:0]                       bucket_q;
	logic [FW-1:0]                       fill_q;
	logic [SW-1:0]                       slot_q;
	logic                                hit_q;
	logic                                full_q;
	logic [blit_pkg::ORDER_W-1:0]        order_q;
	logic [blit_pkg::ORDER_W-1:0]        new_cnt_q;
	logic [blit_pkg::ORDER_W-1:0]        old_cnt_q;
	logic [blit_pkg::COUNT_W-1:0]        logged_q;
	logic [FAW-1:0]                      clr_q;
	logic                                rsp_valid_q;
	blit_pkg::rsp_t                      rsp_q;

	logic                                req_acc;
	logic                                rem_done;
	logic [BW-1:0]                       rem_val;
	logic [FAW-1:0]                      row;
	logic [SAW-1:0]                      slot_addr;
	logic                                fill_we;
	logic [FAW-1:0]                      fill_waddr;
	logic [FW-1:0]                       fill_wdata;
	logic [FW-1:0]                       fill_rdata;
	logic                                slot_we;
	blit_pkg::slot_t                     slot_wr;
	logic [SLOT_BITS-1:0]                slot_rdata;
	blit_pkg::slot_t                     slot_rd;
	logic                                upd_go;
	logic                                do_write;
	logic                                new_id;
	logic [blit_pkg::ORDER_W-1:0]        cnt_cur;
	logic [blit_pkg::ORDER_W-1:0]        cnt_next;
	logic [blit_pkg::COUNT_W-1:0]        logged_next;
	blit_pkg::rsp_t                      res;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;

	blit_rem #(
		.DIVISOR (NUM_BUCKETS)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_acc),
		.dividend  (req.chunk_id),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// Old-log rows follow the new-log rows in both memories.
	assign row       = use_old_q ? ROW_OLD_BASE + FAW'(bucket_q) : FAW'(bucket_q);
	assign slot_addr = SAW'(row) * SLOT_STRIDE + SAW'(slot_q);

	// Update step: leave only when the output register is free.
	assign upd_go   = (state_q == S_UPD) && (!rsp_valid_q || rsp_ready);
	assign do_write = is_rec_q && !full_q;
	assign new_id   = do_write && !hit_q;
	assign cnt_cur  = use_old_q ? old_cnt_q : new_cnt_q;
	assign cnt_next = (cnt_cur == blit_pkg::ORDER_MAX) ? cnt_cur : cnt_cur + 1'b1;
	assign logged_next = (new_id && !use_old_q && (logged_q != blit_pkg::COUNT_MAX)) ?
		logged_q + 1'b1 : logged_q;

	assign fill_we    = (state_q == S_CLEAR) || (upd_go && new_id);
	assign fill_waddr = (state_q == S_CLEAR) ? clr_q : row;
	assign fill_wdata = (state_q == S_CLEAR) ? '0 : FW'(fill_q + 1'b1);

	assign slot_we  = upd_go && do_write;
	assign slot_wr  = '{id: req_q.chunk_id, order: cnt_cur};
	assign slot_rd  = blit_pkg::slot_t'(slot_rdata);

	blit_ram #(
		.WIDTH (FW),
		.DEPTH (ROWS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (row),
		.rdata (fill_rdata)
	);

	blit_ram #(
		.WIDTH (SLOT_BITS),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_addr),
		.wdata (slot_wr),
		.raddr (slot_addr),
		.rdata (slot_rdata)
	);

	always_comb begin
		res.need_old_data = new_id && !use_old_q;
		res.logged_chunks = logged_next;
		if (full_q) begin
			res.status  = blit_pkg::STATUS_FULL;
			res.log_pos = '0;
		end else if (do_write) begin
			res.status  = blit_pkg::STATUS_OK;
			res.log_pos = cnt_cur;
		end else if (hit_q) begin
			res.status  = blit_pkg::STATUS_OK;
			res.log_pos = order_q;
		end else begin
			res.status  = blit_pkg::STATUS_MISS;
			res.log_pos = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			is_rec_q    <= 1'b0;
			use_old_q   <= 1'b0;
			new_cnt_q   <= '0;
			old_cnt_q   <= '0;
			logged_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						is_rec_q  <= req.req_type inside {blit_pkg::REQ_RECORD_NEW,
							blit_pkg::REQ_RECORD_OLD};
						use_old_q <= req.req_type inside {blit_pkg::REQ_RECORD_OLD,
							blit_pkg::REQ_LOOKUP_OLD};
						state_q   <= S_REM;
					end
				end
				S_REM: begin
					if (rem_done) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					hit_q  <= 1'b0;
					full_q <= is_rec_q && (fill_rdata == FILL_FULL);
					if ((is_rec_q && (fill_rdata == FILL_FULL)) || (fill_rdata == '0)) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (slot_rd.id == req_q.chunk_id) begin
						hit_q   <= 1'b1;
						state_q <= S_UPD;
					end else if (FW'(slot_q) + FW'(1'b1) == fill_q) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_UPD: begin
					if (upd_go) begin
						if (do_write) begin
							if (use_old_q) begin
								old_cnt_q <= cnt_next;
							end else begin
								new_cnt_q <= cnt_next;
							end
						end
						logged_q <= logged_next;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if ((state_q == S_REM) && rem_done) begin
			bucket_q <= rem_val;
		end
		if (state_q == S_CHECK) begin
			fill_q <= fill_rdata;
			slot_q <= '0;
		end
		if (state_q == S_CMP) begin
			if (slot_rd.id == req_q.chunk_id) begin
				order_q <= slot_rd.order;
			end else if (FW'(slot_q) + FW'(1'b1) == fill_q) begin
				// Miss: point at the first free slot for the insert.
				slot_q <= fill_q[SW-1:0];
			end else begin
				slot_q <= SW'(slot_q + 1'b1);
			end
		end
		if (upd_go) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BLIT_ASSERT(a_busy_after_accept, clk, arst_n, (req_valid && req_ready) |=> !req_ready)
	`BLIT_ASSERT(a_fill_bound, clk, arst_n, fill_we |-> (fill_wdata <= FILL_FULL))
	`BLIT_ASSERT(a_slot_write_not_full, clk, arst_n, slot_we |-> (is_rec_q && !full_q))
	`BLIT_ASSERT(a_rsp_from_upd, clk, arst_n, $rose(rsp_valid) |-> $past(state_q == S_UPD))
	`BLIT_ASSERT(a_new_cnt_mono, clk, arst_n, 1'b1 |=> (new_cnt_q >= $past(new_cnt_q)))
	`BLIT_NEVER(a_hit_no_fill_write, clk, arst_n, fill_we && hit_q && (state_q == S_UPD))

endmodule

/* sv/blit_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module blit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/blit_rem.sv */
// Remainder unit: chunk id modulo a constant bucket count by reciprocal multiplication.
// Depends on blit_pkg for the id width; start passes through step_q and done_q, and the remainder is valid with done.
module blit_rem #(
	parameter int DIVISOR = 64,
	localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [blit_pkg::ID_W-1:0] dividend,
	output logic                      done,
	output logic [RW-1:0]             remainder
);

	localparam int XW  = blit_pkg::ID_W;
	localparam int LW  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
	localparam int SH  = XW + LW;
	localparam int MW  = XW + 1;
	localparam int PW  = XW + MW;
	localparam int DW  = $clog2(DIVISOR + 1);
	localparam int QNW = XW + DW;
	// Rounded-up reciprocal: gives the exact quotient for every XW-bit dividend.
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
	localparam logic [DW-1:0] DIV_N   = DW'(DIVISOR);

	logic           step_q;
	logic           done_q;
	logic [XW-1:0]  x_q;
	logic [XW-1:0]  quot_q;
	logic [PW-1:0]  prod;
	logic [QNW-1:0] back;
	logic [XW-1:0]  diff;

	assign prod = PW'(x_q) * PW'(RECIP_M);
	assign back = QNW'(quot_q) * QNW'(DIV_N);
	assign diff = x_q - back[XW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= start;
			done_q <= step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (step_q) begin
			quot_q <= XW'(prod >> SH);
		end
	end

	assign done      = done_q;
	assign remainder = diff[RW-1:0];

endmodule

/* test/tb_top.sv */
// Self-checking bench for bucketed_log_index_table_unit: directed and random requests,
// each result predicted from a local copy of both chunk tables and log counters.
// Depends on blit_pkg and the unit's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BUCKETS        = 64;
	localparam int ENTRIES_PER_BUCKET = 8;
	localparam int WATCHDOG_LIMIT     = 4000;
	localparam int DRAIN_CYCLES       = 60;
	localparam int PHASE_ITEMS        = 125;
	localparam int SEND_IDLE_PCT [4]  = '{0, 72, 0, 19};
	localparam int RSP_STALL_PCT [4]  = '{0, 0, 72, 19};
	localparam logic [blit_pkg::REQ_W-1:0] REQ_KINDS [4] =
		'{blit_pkg::REQ_RECORD_NEW, blit_pkg::REQ_RECORD_OLD,
		blit_pkg::REQ_LOOKUP_NEW, blit_pkg::REQ_LOOKUP_OLD};
	localparam logic [blit_pkg::ID_W-1:0] ID_ALL_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	blit_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	blit_pkg::rsp_t rsp;

	// Local image of both tables: index 0 is the new-log table, 1 the old-log table.
	logic                         chunk_valid  [2][NUM_BUCKETS][ENTRIES_PER_BUCKET];
	logic [blit_pkg::ID_W-1:0]    chunk_ids    [2][NUM_BUCKETS][ENTRIES_PER_BUCKET];
	logic [blit_pkg::ORDER_W-1:0] chunk_orders [2][NUM_BUCKETS][ENTRIES_PER_BUCKET];
	logic [blit_pkg::ORDER_W-1:0] log_position [2];
	logic [blit_pkg::COUNT_W-1:0] logged_distinct;

	blit_pkg::req_t            pending_reqs [$];
	blit_pkg::rsp_t            expected_rsps [$];
	logic [blit_pkg::ID_W-1:0] known_ids [$];
	int                        send_idle_pct = 0;
	int                        rsp_stall_pct = 0;
	int                        fail_count = 0;
	int                        idle_cycles;

	bucketed_log_index_table_unit #(
		.NUM_BUCKETS       (NUM_BUCKETS),
		.ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int t = 0; t < 2; t++) begin
			log_position[t] = '0;
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				for (int s = 0; s < ENTRIES_PER_BUCKET; s++) begin
					chunk_valid[t][b][s]  = 1'b0;
					chunk_ids[t][b][s]    = '0;
					chunk_orders[t][b][s] = '0;
				end
			end
		end
		logged_distinct = '0;
	end

	// Apply one request to the local tables and return the result it must produce.
	function automatic blit_pkg::rsp_t predict_response(blit_pkg::req_t r);
		blit_pkg::rsp_t res;
		int             side;
		int             bucket;
		int             hit;
		int             free_slot;
		res = '0;
		side = (r.req_type == blit_pkg::REQ_RECORD_OLD ||
			r.req_type == blit_pkg::REQ_LOOKUP_OLD) ? 1 : 0;
		bucket = r.chunk_id % NUM_BUCKETS;
		hit = -1;
		free_slot = -1;
		for (int s = 0; s < ENTRIES_PER_BUCKET; s++) begin
			if (chunk_valid[side][bucket][s] && chunk_ids[side][bucket][s] == r.chunk_id
					&& hit < 0)
				hit = s;
			if (!chunk_valid[side][bucket][s] && free_slot < 0)
				free_slot = s;
		end
		if (r.req_type == blit_pkg::REQ_RECORD_NEW || r.req_type == blit_pkg::REQ_RECORD_OLD)
				begin
			// A bucket with its last slot taken refuses every record, even a known id.
			if (chunk_valid[side][bucket][ENTRIES_PER_BUCKET-1]) begin
				res.status = blit_pkg::STATUS_FULL;
			end else begin
				if (hit < 0) begin
					hit = free_slot;
					if (side == 0) begin
						res.need_old_data = 1'b1;
						if (logged_distinct != blit_pkg::COUNT_MAX)
							logged_distinct++;
					end
				end
				chunk_valid[side][bucket][hit]  = 1'b1;
				chunk_ids[side][bucket][hit]    = r.chunk_id;
				chunk_orders[side][bucket][hit] = log_position[side];
				res.status  = blit_pkg::STATUS_OK;
				res.log_pos = log_position[side];
				if (log_position[side] != blit_pkg::ORDER_MAX)
					log_position[side]++;
			end
		end else if (hit < 0) begin
			res.status = blit_pkg::STATUS_MISS;
		end else begin
			res.status  = blit_pkg::STATUS_OK;
			res.log_pos = chunk_orders[side][bucket][hit];
		end
		res.logged_chunks = logged_distinct;
		return res;
	endfunction

	// Mostly ids already used, many new ids crowded into a few buckets so they fill up,
	// and the rest spread over the whole id range.
	function automatic blit_pkg::req_t random_request();
		blit_pkg::req_t r;
		int unsigned    pick;
		pick = $urandom_range(99);
		r.req_type = REQ_KINDS[($urandom_range(99) < 60) ? $urandom_range(1) :
			2 + $urandom_range(1)];
		if (pick < 55 && known_ids.size() > 0) begin
			r.chunk_id = known_ids[$urandom_range(known_ids.size() - 1)];
		end else begin
			if (pick < 85)
				r.chunk_id = {14'($urandom), 6'($urandom_range(11))};
			else
				r.chunk_id = blit_pkg::ID_W'($urandom);
			known_ids.push_back(r.chunk_id);
		end
		return r;
	endfunction

	task automatic queue_request(logic [blit_pkg::REQ_W-1:0] kind,
			logic [blit_pkg::ID_W-1:0] id);
		blit_pkg::req_t r;
		r.req_type = kind;
		r.chunk_id = id;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
	endtask

	task automatic report(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		fail_count++;
	endtask

	// Request driver: predict on each accepted transaction, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_response(req));
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest prediction, stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result, expected nothing, actual %0h",
						$time, rsp);
					fail_count++;
				end else begin
					if (rsp.status !== expected_rsps[0].status)
						report("status", expected_rsps[0].status, rsp.status);
					if (rsp.need_old_data !== expected_rsps[0].need_old_data)
						report("need_old_data", expected_rsps[0].need_old_data,
							rsp.need_old_data);
					if (rsp.log_pos !== expected_rsps[0].log_pos)
						report("log_pos", expected_rsps[0].log_pos, rsp.log_pos);
					if (rsp.logged_chunks !== expected_rsps[0].logged_chunks)
						report("logged_chunks", expected_rsps[0].logged_chunks,
							rsp.logged_chunks);
					void'(expected_rsps.pop_front());
				end
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Lookups in empty tables miss.
		queue_request(blit_pkg::REQ_LOOKUP_NEW, '0);
		queue_request(blit_pkg::REQ_LOOKUP_OLD, ID_ALL_ONES);
		// First record of an id asks for old data; a repeat does not, but moves the id to the next position.
		queue_request(blit_pkg::REQ_RECORD_NEW, '0);
		queue_request(blit_pkg::REQ_RECORD_NEW, '0);
		queue_request(blit_pkg::REQ_LOOKUP_NEW, '0);
		// Old-log records never touch the distinct count.
		queue_request(blit_pkg::REQ_RECORD_OLD, ID_ALL_ONES);
		queue_request(blit_pkg::REQ_LOOKUP_OLD, ID_ALL_ONES);
		queue_request(blit_pkg::REQ_RECORD_OLD, ID_ALL_ONES);
		// Fill the top bucket of the new table, then hit it when full.
		for (int j = 0; j < ENTRIES_PER_BUCKET - 1; j++)
			queue_request(blit_pkg::REQ_RECORD_NEW,
				blit_pkg::ID_W'(j * NUM_BUCKETS + NUM_BUCKETS - 1));
		queue_request(blit_pkg::REQ_RECORD_NEW, ID_ALL_ONES);
		queue_request(blit_pkg::REQ_RECORD_NEW, ID_ALL_ONES);
		queue_request(blit_pkg::REQ_RECORD_NEW, blit_pkg::ID_W'(NUM_BUCKETS - 1));
		queue_request(blit_pkg::REQ_RECORD_NEW, blit_pkg::ID_W'('h8003F));
		queue_request(blit_pkg::REQ_LOOKUP_NEW, ID_ALL_ONES);
		queue_request(blit_pkg::REQ_LOOKUP_NEW, blit_pkg::ID_W'('h8003F));
		queue_request(blit_pkg::REQ_LOOKUP_OLD, blit_pkg::ID_W'(NUM_BUCKETS - 1));
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = SEND_IDLE_PCT[phase];
			rsp_stall_pct = RSP_STALL_PCT[phase];
			repeat (PHASE_ITEMS)
				pending_reqs.push_back(random_request());
			// Hold the sender until every result of this phase is back.
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_rsps.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
